### rtl/core/tile_index_to_coordinate_defines.svh
// Assertion macros for the tile locator checker.
`ifndef TILE_INDEX_TO_COORDINATE_DEFINES_SVH
`define TILE_INDEX_TO_COORDINATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tic_pkg.sv
// Types and constants shared by the tile locator modules.
`default_nettype none
package tic_pkg;

  localparam int MAX_FILES  = 16;
  localparam int MAX_LEVELS = 8;
  localparam int DIM_BITS   = 20;
  localparam int IDX_BITS   = 44;
  localparam int DVS_BITS   = 21;
  localparam int CNT_BITS   = 6;

  localparam logic [12:0] TILE_LIMIT = 13'd4096;
  localparam logic [4:0]  FILE_LIMIT = 5'd16;
  localparam logic [3:0]  LEVEL_LIMIT = 4'd8;

  localparam logic [1:0] FUNC_LOAD_DIM = 2'd0;
  localparam logic [1:0] FUNC_LOAD_LVL = 2'd1;
  localparam logic [1:0] FUNC_LOCATE   = 2'd2;

  localparam logic [1:0] CFG_TILE_W     = 2'd0;
  localparam logic [1:0] CFG_TILE_H     = 2'd1;
  localparam logic [1:0] CFG_LEVEL_SEL  = 2'd2;
  localparam logic [1:0] CFG_FILE_COUNT = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_WGO, ST_LD_W, ST_LD_HGO, ST_LD_H, ST_LD_WR,
    ST_WF_WAIT, ST_WF, ST_WE_WAIT, ST_WE,
    ST_FB_WAIT, ST_FB,
    ST_DIM_WAIT, ST_DIM, ST_DW, ST_DHGO, ST_DH, ST_DLGO, ST_DL,
    ST_MUL, ST_RESP
  } tic_state_t;

endpackage
`default_nettype wire

### rtl/core/tile_index_to_coordinate.sv
// Tile locator top level: dimension table, table walk and tile rectangle.
// A load of dimensions runs two divisions and a table write; a level-count
// load or an unused function goes straight to the response; a locate reads
// the table for each file and level entry visited in the walk, then runs
// three divisions and a multiply for the rectangle. All divisions use the
// single shared restoring divider, one quotient bit per cycle over 44 bits,
// used twice per load and three times per locate, and every table read is
// registered. The block takes one transaction
// at a time; a result waits in the output register until taken.
`default_nettype none
module tile_index_to_coordinate (
  input  wire          clk,
  input  wire          rst_n,
  // func, file_sel, level_sel, img_width, img_height, levels_in_file, global_tile
  input  wire  [103:0] in_tdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // file_out, level_out, origin_x, origin_y, clip_w, clip_h, found
  output logic [79:0]  out_tdata,
  output logic         out_tvalid,
  input  wire          out_tready,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [12:0]  cfg_wdata
);
  import tic_pkg::*;

  tic_state_t state_r, state_nxt;
  logic [12:0] tw_cfg_r, th_cfg_r;
  logic [3:0]  lsel_cfg_r;
  logic [4:0]  fc_cfg_r;

  logic [3:0]  fsel_r, fsel_nxt;
  logic [2:0]  lsel_r, lsel_nxt;
  logic [DIM_BITS-1:0] win_r, win_nxt, hin_r, hin_nxt;
  logic [IDX_BITS-1:0] tidx_r, tidx_nxt, local_r, local_nxt;
  logic [3:0]  f_r, f_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [3:0]  nl_r, nl_nxt;
  logic [46:0] base_r, base_nxt;
  logic        found_r, found_nxt, ack_r, ack_nxt;
  logic [20:0] cols_r, cols_nxt, rows_r, rows_nxt, qs_r, qs_nxt, qrem_r, qrem_nxt;
  logic [DIM_BITS-1:0] wdim_r, wdim_nxt, hdim_r, hdim_nxt;
  logic [12:0] wrem_r, wrem_nxt, hrem_r, hrem_nxt;
  logic [33:0] x_r, x_nxt, y_r, y_nxt;
  logic        out_valid_r;
  logic [79:0] out_data_r, out_data_nxt;
  logic        out_load;

  logic [12:0] tw, th;
  logic [4:0]  fc;
  logic        walk_all;
  logic [2:0]  sel;

  logic        div_start;
  logic [IDX_BITS-1:0] div_a, div_q;
  logic [DVS_BITS-1:0] div_b, div_r;
  div_stat_t   div_st;
  logic [20:0] div_ceil;

  logic [39:0] tiles_mem [MAX_FILES*MAX_LEVELS];
  logic [DIM_BITS-1:0] w_mem [MAX_FILES*MAX_LEVELS];
  logic [DIM_BITS-1:0] h_mem [MAX_FILES*MAX_LEVELS];
  logic [3:0]  lv_mem [MAX_FILES];
  logic [39:0] tiles_q;
  logic [DIM_BITS-1:0] w_q, h_q;
  logic [3:0]  lv_q, nl_q;
  logic        tiles_we;
  logic        in_acc;

  logic [46:0] base_end;
  logic [4:0]  f_inc;
  logic [3:0]  j_inc;
  logic [34:0] x_end, y_end;
  logic [12:0] cw, ch;
  logic [19:0] ox, oy;

  assign tw = (tw_cfg_r == 13'd0) ? 13'd1 : ((tw_cfg_r > TILE_LIMIT) ? TILE_LIMIT : tw_cfg_r);
  assign th = (th_cfg_r == 13'd0) ? 13'd1 : ((th_cfg_r > TILE_LIMIT) ? TILE_LIMIT : th_cfg_r);
  assign fc = (fc_cfg_r == 5'd0) ? 5'd1 : ((fc_cfg_r > FILE_LIMIT) ? FILE_LIMIT : fc_cfg_r);
  assign walk_all = lsel_cfg_r[3];
  assign sel      = lsel_cfg_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_cfg_r   <= 13'd256;
      th_cfg_r   <= 13'd256;
      lsel_cfg_r <= 4'hF;
      fc_cfg_r   <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TILE_W:     tw_cfg_r   <= cfg_wdata;
        CFG_TILE_H:     th_cfg_r   <= cfg_wdata;
        CFG_LEVEL_SEL:  lsel_cfg_r <= cfg_wdata[3:0];
        CFG_FILE_COUNT: fc_cfg_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  tic_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_st)
  );

  assign div_ceil = div_q[20:0] + {20'd0, (div_r != '0)};

  // table memories, registered read at the walk pointer
  always_ff @(posedge clk) begin
    if (tiles_we) begin
      tiles_mem[{fsel_r, lsel_r}] <= 40'(rows_r * cols_r);
      w_mem[{fsel_r, lsel_r}]     <= win_r;
      h_mem[{fsel_r, lsel_r}]     <= hin_r;
    end
    tiles_q <= tiles_mem[{f_r, j_r}];
    w_q     <= w_mem[{f_r, j_r}];
    h_q     <= h_mem[{f_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tdata[1:0] == FUNC_LOAD_LVL) begin
      lv_mem[in_tdata[5:2]] <= in_tdata[52:49];
    end
    lv_q <= lv_mem[f_r];
  end

  assign nl_q     = (lv_q > LEVEL_LIMIT) ? LEVEL_LIMIT : lv_q;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign base_end  = base_r + {7'd0, tiles_q};
  assign f_inc     = {1'b0, f_r} + 5'd1;
  assign j_inc     = {1'b0, j_r} + 4'd1;
  assign x_end     = {1'b0, x_r} + {22'd0, tw};
  assign y_end     = {1'b0, y_r} + {22'd0, th};
  assign cw        = (x_end > {15'd0, wdim_r}) ? wrem_r : tw;
  assign ch        = (y_end > {15'd0, hdim_r}) ? hrem_r : th;
  assign ox        = (x_r > 34'hFFFFF) ? 20'hFFFFF : x_r[19:0];
  assign oy        = (y_r > 34'hFFFFF) ? 20'hFFFFF : y_r[19:0];

  always_comb begin
    state_nxt = state_r;
    fsel_nxt = fsel_r;  lsel_nxt = lsel_r;
    win_nxt = win_r;    hin_nxt = hin_r;
    tidx_nxt = tidx_r;  local_nxt = local_r;
    f_nxt = f_r;        j_nxt = j_r;       nl_nxt = nl_r;
    base_nxt = base_r;  found_nxt = found_r; ack_nxt = ack_r;
    cols_nxt = cols_r;  rows_nxt = rows_r;
    qs_nxt = qs_r;      qrem_nxt = qrem_r;
    wdim_nxt = wdim_r;  hdim_nxt = hdim_r;
    wrem_nxt = wrem_r;  hrem_nxt = hrem_r;
    x_nxt = x_r;        y_nxt = y_r;
    out_data_nxt = out_data_r;
    out_load = 1'b0;
    tiles_we = 1'b0;
    div_start = 1'b0;
    div_a = {24'd0, win_r};
    div_b = {8'd0, tw};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fsel_nxt = in_tdata[5:2];
          lsel_nxt = in_tdata[8:6];
          win_nxt  = in_tdata[28:9];
          hin_nxt  = in_tdata[48:29];
          tidx_nxt = in_tdata[96:53];
          ack_nxt  = 1'b1;
          case (in_tdata[1:0])
            FUNC_LOAD_DIM: state_nxt = ST_LD_WGO;
            FUNC_LOCATE: begin
              ack_nxt   = 1'b0;
              f_nxt     = '0;
              j_nxt     = '0;
              base_nxt  = '0;
              state_nxt = ST_WF_WAIT;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_LD_WGO: begin
        div_start = 1'b1;
        state_nxt = ST_LD_W;
      end
      ST_LD_W: begin
        if (div_st.done) begin
          cols_nxt  = div_ceil;
          state_nxt = ST_LD_HGO;
        end
      end
      ST_LD_HGO: begin
        div_a = {24'd0, hin_r};
        div_b = {8'd0, th};
        div_start = 1'b1;
        state_nxt = ST_LD_H;
      end
      ST_LD_H: begin
        if (div_st.done) begin
          rows_nxt  = div_ceil;
          state_nxt = ST_LD_WR;
        end
      end
      ST_LD_WR: begin
        tiles_we  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_WF_WAIT: state_nxt = ST_WF;
      ST_WF: begin
        nl_nxt = nl_q;
        if (walk_all && nl_q != 4'd0) begin
          j_nxt = '0;
          state_nxt = ST_WE_WAIT;
        end else if (!walk_all && {1'b0, sel} < nl_q) begin
          j_nxt = sel;
          state_nxt = ST_WE_WAIT;
        end else if (f_inc < fc) begin
          f_nxt = f_inc[3:0];
          state_nxt = ST_WF_WAIT;
        end else begin
          state_nxt = ST_FB_WAIT;
        end
      end
      ST_WE_WAIT: state_nxt = ST_WE;
      ST_WE: begin
        if ({3'd0, tidx_r} < base_end) begin
          local_nxt = tidx_r - base_r[IDX_BITS-1:0];
          found_nxt = 1'b1;
          state_nxt = ST_DIM_WAIT;
        end else begin
          base_nxt = base_end;
          if (walk_all && j_inc < nl_r) begin
            j_nxt = j_inc[2:0];
            state_nxt = ST_WE_WAIT;
          end else if (f_inc < fc) begin
            f_nxt = f_inc[3:0];
            state_nxt = ST_WF_WAIT;
          end else begin
            state_nxt = ST_FB_WAIT;
          end
        end
        if (state_nxt == ST_FB_WAIT) begin
          f_nxt = 4'(fc - 5'd1);
        end
      end
      ST_FB_WAIT: begin
        f_nxt = 4'(fc - 5'd1);
        local_nxt = tidx_r - base_r[IDX_BITS-1:0];
        found_nxt = 1'b0;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        j_nxt = (nl_q == 4'd0) ? 3'd0 : 3'(nl_q - 4'd1);
        state_nxt = ST_DIM_WAIT;
      end
      ST_DIM_WAIT: state_nxt = ST_DIM;
      ST_DIM: begin
        wdim_nxt = w_q;
        hdim_nxt = h_q;
        div_a = {24'd0, w_q};
        div_start = 1'b1;
        state_nxt = ST_DW;
      end
      ST_DW: begin
        if (div_st.done) begin
          cols_nxt  = (div_ceil == 21'd0) ? 21'd1 : div_ceil;
          wrem_nxt  = div_r[12:0];
          state_nxt = ST_DHGO;
        end
      end
      ST_DHGO: begin
        div_a = {24'd0, hdim_r};
        div_b = {8'd0, th};
        div_start = 1'b1;
        state_nxt = ST_DH;
      end
      ST_DH: begin
        if (div_st.done) begin
          hrem_nxt  = div_r[12:0];
          state_nxt = ST_DLGO;
        end
      end
      ST_DLGO: begin
        div_a = local_r;
        div_b = cols_r;
        div_start = 1'b1;
        state_nxt = ST_DL;
      end
      ST_DL: begin
        if (div_st.done) begin
          qs_nxt    = (div_q > 44'h100000) ? 21'h100000 : div_q[20:0];
          qrem_nxt  = div_r;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        x_nxt = tw * qrem_r;
        y_nxt = th * qs_r;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          if (ack_r) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt = {6'd0, found_r, ch, cw, oy, ox, j_r, f_r};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fsel_r <= fsel_nxt;   lsel_r <= lsel_nxt;
    win_r <= win_nxt;     hin_r <= hin_nxt;
    tidx_r <= tidx_nxt;   local_r <= local_nxt;
    f_r <= f_nxt;         j_r <= j_nxt;       nl_r <= nl_nxt;
    base_r <= base_nxt;   found_r <= found_nxt; ack_r <= ack_nxt;
    cols_r <= cols_nxt;   rows_r <= rows_nxt;
    qs_r <= qs_nxt;       qrem_r <= qrem_nxt;
    wdim_r <= wdim_nxt;   hdim_r <= hdim_nxt;
    wrem_r <= wrem_nxt;   hrem_r <= hrem_nxt;
    x_r <= x_nxt;         y_r <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/core/tic_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module tic_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [tic_pkg::IDX_BITS-1:0] dividend,
  input  wire [tic_pkg::DVS_BITS-1:0] divisor,
  output logic [tic_pkg::IDX_BITS-1:0] quotient,
  output logic [tic_pkg::DVS_BITS-1:0] remainder,
  output tic_pkg::div_stat_t         stat
);
  import tic_pkg::*;

  logic [IDX_BITS-1:0] quo_r;
  logic [DVS_BITS-1:0] rem_r, dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DVS_BITS:0]   sh, diff;
  logic                ge;

  assign sh   = {rem_r, quo_r[IDX_BITS-1]};
  assign ge   = sh >= {1'b0, dvs_r};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(IDX_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[IDX_BITS-2:0], ge};
      rem_r <= ge ? diff[DVS_BITS-1:0] : sh[DVS_BITS-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

### rtl/core/tic_checker.sv
// Port-level checker for the tile locator, bound to the top level.
`default_nettype none
`include "tile_index_to_coordinate_defines.svh"
module tic_checker (
  input wire         clk,
  input wire         rst_n,
  input wire [103:0] in_tdata,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire [79:0]  out_tdata,
  input wire         out_tvalid,
  input wire         out_tready
);

  `TIC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `TIC_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready right after a transaction")
  `TIC_ASSERT_IMP(a_clip_range, out_tvalid, out_tdata[59:47] <= 13'd4096 && out_tdata[72:60] <= 13'd4096, "clip size above 4096")

endmodule

bind tile_index_to_coordinate tic_checker u_tic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire

### verif/tile_index_to_coordinate_tb.sv
// Testbench for the tile locator: table loads, tile walks and rectangle checks.
`timescale 1ns / 100ps
module tile_index_to_coordinate_tb;
  import tic_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam longint unsigned TILE_SAT = (64'd1 << 40) - 1;
  localparam longint unsigned DIM_MAX = (64'd1 << DIM_BITS) - 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  file_sel;
    logic [2:0]  level_sel;
    logic [19:0] img_width;
    logic [19:0] img_height;
    logic [3:0]  levels_in_file;
    logic [43:0] global_tile;
  } query_t;

  // packed exactly as out_tdata[73:0]
  typedef struct packed {
    logic        found;
    logic [12:0] clip_h;
    logic [12:0] clip_w;
    logic [19:0] origin_y;
    logic [19:0] origin_x;
    logic [2:0]  level_out;
    logic [3:0]  file_out;
  } tile_rect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [103:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [12:0] cfg_wdata = '0;

  tile_index_to_coordinate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow of the block's registers and table
  logic [12:0] tile_w_reg, tile_h_reg;
  logic [3:0]  level_sel_reg;
  logic [4:0]  file_count_reg;
  longint unsigned width_tbl [MAX_FILES*MAX_LEVELS];
  longint unsigned height_tbl [MAX_FILES*MAX_LEVELS];
  longint unsigned tiles_tbl [MAX_FILES*MAX_LEVELS];
  logic [3:0] levels_tbl [MAX_FILES];

  query_t query_q[$];
  tile_rect_t rect_q[$];
  query_t cur_query;
  bit in_took = 0;
  bit idle_on = 1;
  int in_gap = 0;
  int out_gap = 0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned eff_tile(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic longint unsigned eff_files();
    if (file_count_reg == 0) return 1;
    if (file_count_reg > MAX_FILES) return MAX_FILES;
    return file_count_reg;
  endfunction

  function automatic longint unsigned eff_levels(longint unsigned f);
    return (levels_tbl[f] > MAX_LEVELS) ? MAX_LEVELS : levels_tbl[f];
  endfunction

  // tiles reachable by the walk under the current settings
  function automatic longint unsigned walk_total();
    longint unsigned sum = 0;
    for (longint unsigned f = 0; f < eff_files(); f++)
      for (longint unsigned j = 0; j < eff_levels(f); j++)
        if (level_sel_reg[3] || j == level_sel_reg[2:0]) sum += tiles_tbl[f*MAX_LEVELS+j];
    return sum;
  endfunction

  function automatic tile_rect_t apply_query(query_t q);
    tile_rect_t r;
    longint unsigned tw, th, e, cols, rows, n, base, local_idx, fo, lo, nl, x, y, cw, ch;
    bit hit;
    r = '0;
    tw = eff_tile(tile_w_reg);
    th = eff_tile(tile_h_reg);
    case (q.func)
      FUNC_LOAD_DIM: begin
        e = q.file_sel * MAX_LEVELS + q.level_sel;
        cols = (q.img_width + tw - 1) / tw;
        rows = (q.img_height + th - 1) / th;
        if (rows != 0 && cols > TILE_SAT / rows) n = TILE_SAT;
        else n = rows * cols;
        width_tbl[e] = 64'(q.img_width);
        height_tbl[e] = 64'(q.img_height);
        tiles_tbl[e] = n;
      end
      FUNC_LOAD_LVL: levels_tbl[q.file_sel] = q.levels_in_file;
      FUNC_LOCATE: begin
        base = 0; local_idx = 0; fo = 0; lo = 0; hit = 0;
        for (longint unsigned f = 0; f < eff_files() && !hit; f++) begin
          nl = eff_levels(f);
          for (longint unsigned j = 0; j < nl; j++) begin
            if (!level_sel_reg[3] && j != level_sel_reg[2:0]) continue;
            n = tiles_tbl[f*MAX_LEVELS+j];
            if (base <= q.global_tile && q.global_tile < base + n) begin
              fo = f; lo = j; local_idx = q.global_tile - base; hit = 1;
              break;
            end
            base += n;
          end
        end
        if (!hit) begin
          fo = eff_files() - 1;
          nl = eff_levels(fo);
          lo = (nl == 0) ? 0 : nl - 1;
          local_idx = q.global_tile - base;
        end
        e = fo * MAX_LEVELS + lo;
        cols = (width_tbl[e] + tw - 1) / tw;
        if (cols == 0) cols = 1;
        y = th * (local_idx / cols);
        x = tw * (local_idx % cols);
        cw = tw; ch = th;
        if (y + th > height_tbl[e]) ch = height_tbl[e] % th;
        if (x + tw > width_tbl[e]) cw = width_tbl[e] % tw;
        r.file_out = 4'(fo);
        r.level_out = 3'(lo);
        r.origin_x = 20'((x > DIM_MAX) ? DIM_MAX : x);
        r.origin_y = 20'((y > DIM_MAX) ? DIM_MAX : y);
        r.clip_w = 13'(cw);
        r.clip_h = 13'(ch);
        r.found = hit;
      end
      default: ;
    endcase
    return r;
  endfunction

  // input driver
  always @(negedge clk) begin
    logic nv;
    logic [103:0] nd;
    if (rst_n && !(in_tvalid && !in_took)) begin
      nv = 1'b0;
      nd = in_tdata;
      if (in_gap > 0) in_gap--;
      else if (query_q.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(0, 9);
        else begin
          cur_query = query_q.pop_front();
          nv = 1'b1;
          nd = {7'd0, cur_query.global_tile, cur_query.levels_in_file, cur_query.img_height,
                cur_query.img_width, cur_query.level_sel, cur_query.file_sel, cur_query.func};
        end
      end
      in_tvalid <= nv;
      in_tdata <= nd;
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      nr = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 9);
      nr = 1'b0;
    end
    out_tready <= rst_n ? nr : 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    tile_rect_t got, want;
    in_took = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_took) rect_q.push_back(apply_query(cur_query));
      if (out_tvalid && out_tready) begin
        got = out_tdata[73:0];
        if (rect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = rect_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch exp file %0d lvl %0d x %0d y %0d w %0d h %0d found %0b",
                     $time, want.file_out, want.level_out, want.origin_x, want.origin_y,
                     want.clip_w, want.clip_h, want.found);
            $display("%0t:          act file %0d lvl %0d x %0d y %0d w %0d h %0d found %0b",
                     $time, got.file_out, got.level_out, got.origin_x, got.origin_y,
                     got.clip_w, got.clip_h, got.found);
          end
        end
      end
      if (in_took || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tile_index_to_coordinate_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] addr, logic [12:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_TILE_W: tile_w_reg = data;
      CFG_TILE_H: tile_h_reg = data;
      CFG_LEVEL_SEL: level_sel_reg = data[3:0];
      default: file_count_reg = data[4:0];
    endcase
  endtask

  task automatic set_regs(logic [12:0] tw, logic [12:0] th, logic [3:0] ls, logic [4:0] fc);
    write_reg(CFG_TILE_W, tw);
    write_reg(CFG_TILE_H, th);
    write_reg(CFG_LEVEL_SEL, {9'd0, ls});
    write_reg(CFG_FILE_COUNT, {8'd0, fc});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (query_q.size() != 0 || in_tvalid || rect_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_dim(int f, int l, logic [19:0] w, logic [19:0] h);
    query_t q;
    q = '0;
    q.func = FUNC_LOAD_DIM;
    q.file_sel = 4'(f); q.level_sel = 3'(l);
    q.img_width = w; q.img_height = h;
    q.levels_in_file = 4'($urandom); q.global_tile = 44'({$urandom, $urandom});
    query_q.push_back(q);
  endtask

  task automatic push_lvl(int f, logic [3:0] n);
    query_t q;
    q = '0;
    q.func = FUNC_LOAD_LVL;
    q.file_sel = 4'(f); q.levels_in_file = n;
    q.level_sel = 3'($urandom); q.img_width = 20'($urandom); q.img_height = 20'($urandom);
    query_q.push_back(q);
  endtask

  task automatic push_locate(logic [43:0] idx);
    query_t q;
    q = '0;
    q.func = FUNC_LOCATE;
    q.global_tile = idx;
    q.file_sel = 4'($urandom); q.level_sel = 3'($urandom);
    q.img_width = 20'($urandom); q.img_height = 20'($urandom);
    q.levels_in_file = 4'($urandom);
    query_q.push_back(q);
  endtask

  function automatic logic [19:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 20'($urandom);
      1: return 20'($urandom_range(0, 3));
      default: return 20'($urandom_range(1, 3000));
    endcase
  endfunction

  // locate index: mostly inside the walk, sometimes at or past its end
  task automatic push_rand_locate();
    longint unsigned tot;
    logic [43:0] idx;
    tot = walk_total();
    case ($urandom_range(0, 9))
      7: idx = 44'(tot + $urandom_range(0, 50));
      8: idx = 44'({$urandom, $urandom});
      9: idx = 44'((tot > 0) ? tot - 1 : 0);
      default: idx = 44'((tot > 0) ? {$urandom, $urandom} % tot : $urandom_range(0, 5));
    endcase
    push_locate(idx);
  endtask

  task automatic run_phase(int count);
    int k;
    query_t q;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      if (k < 14) push_rand_locate();
      else if (k < 17) push_dim($urandom_range(0, 15), $urandom_range(0, 7), rand_dim(), rand_dim());
      else if (k < 19) push_lvl($urandom_range(0, 15), 4'($urandom));
      else begin
        q = 97'({$urandom, $urandom, $urandom, $urandom});
        q.func = FUNC_UNUSED;
        query_q.push_back(q);
      end
      // walk totals depend on earlier loads, so let them apply first
      if (k >= 14) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    tile_w_reg = 13'd256;
    tile_h_reg = 13'd256;
    level_sel_reg = 4'hF;
    file_count_reg = 5'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole table so no walk touches an unwritten entry
    for (int f = 0; f < MAX_FILES; f++)
      push_lvl(f, (f == 0) ? 4'd8 : (f == 1) ? 4'd0 : (f == 2) ? 4'd15 : 4'($urandom_range(0, 15)));
    for (int e = 0; e < MAX_FILES*MAX_LEVELS; e++)
      push_dim(e / MAX_LEVELS, e % MAX_LEVELS, rand_dim(), rand_dim());
    push_dim(0, 0, 20'hFFFFF, 20'hFFFFF);
    push_dim(0, 1, 20'd0, 20'd700);
    push_dim(0, 7, 20'd513, 20'd0);
    wait_drained();

    // directed locates under reset settings
    push_locate(44'd0);
    push_locate('1);
    push_locate(44'(walk_total() - 1));
    push_locate(44'(walk_total()));
    push_locate(44'd4096);
    query_q.push_back({FUNC_UNUSED, 95'('1)});
    wait_drained();

    set_regs(13'd1, 13'd1, 4'hF, 5'd16);
    push_dim(3, 2, 20'hFFFFF, 20'hFFFFF);
    push_dim(3, 3, 20'd1, 20'd1);
    wait_drained();
    push_locate(44'(walk_total() - 1));
    push_locate('1);
    run_phase(60);

    set_regs(13'd0, 13'd8191, 4'd7, 5'd0);
    run_phase(60);
    set_regs(13'd4096, 13'd4096, 4'd0, 5'd31);
    run_phase(60);
    set_regs(13'd100, 13'd37, 4'h8, 5'd5);
    run_phase(70);
    set_regs(13'd4097, 13'd0, 4'd3, 5'd16);
    run_phase(70);
    set_regs(13'd64, 13'd200, 4'hF, 5'd9);
    push_lvl(1, 4'd0);
    wait_drained();
    for (int i = 0; i < 5; i++) push_locate(44'(walk_total() + i));
    run_phase(70);

    idle_on = 0;
    set_regs(13'd256, 13'd128, 4'hF, 5'd16);
    run_phase(70);

    repeat (50) @(posedge clk);
    if (errors == 0) $display("tile_index_to_coordinate_tb: done, clean");
    else $display("tile_index_to_coordinate_tb: done, errors");
    $finish;
  end

endmodule
